// ===== hdl/tsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_pkg: shared types for the two-axis stepper positioner
// Request and register codes, payload structs, configuration set and the
// per-axis control and status bundles.
// ----------------------------------------------------------------------------
package tsp_pkg;

	typedef enum logic [1:0] {
		REQ_TICK   = 2'd0,
		REQ_SET_AZ = 2'd1,
		REQ_SET_EL = 2'd2,
		REQ_STOP   = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_TOLERANCE = 3'd0,
		CFG_THRESHOLD = 3'd1,
		CFG_FAST_HALF = 3'd2,
		CFG_SLOW_HALF = 3'd3,
		CFG_PULSES    = 3'd4
	} cfg_idx_t;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	typedef struct packed {
		req_t        req_type;
		logic [15:0] target_value;
		logic [15:0] cur_az;
		logic [15:0] cur_el;
		logic        limit_az_ok;
		logic        limit_el_ok;
	} in_item_t;

	typedef struct packed {
		logic step_az;
		logic dir_az;
		logic step_el;
		logic dir_el;
		logic moving_az;
		logic moving_el;
	} out_item_t;

	typedef struct packed {
		logic [14:0] reach_tol;
		logic [14:0] speed_threshold;
		logic [15:0] fast_half_period;
		logic [15:0] slow_half_period;
		logic [5:0]  pulses_per_burst;
	} cfg_t;

	localparam logic [14:0] RST_TOLERANCE = 15'd10;
	localparam logic [14:0] RST_THRESHOLD = 15'd500;
	localparam logic [15:0] RST_FAST_HALF = 16'd100;
	localparam logic [15:0] RST_SLOW_HALF = 16'd500;
	localparam logic [5:0]  RST_PULSES    = 6'd10;

	// per-beat controls into one axis
	typedef struct packed {
		logic tick;
		logic set;
		logic stop;
	} axis_ctl_t;

	// pin and status levels for the beat's result
	typedef struct packed {
		logic step;
		logic dir;
		logic moving;
	} axis_stat_t;

endpackage
`default_nettype wire

// ===== hdl/tsp_axis.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsp_axis: one positioner axis
// Holds target, burst counter, phase timer and flags; on a tick with no burst
// running evaluates the error, may start a step burst, advances pulse timing.
// ----------------------------------------------------------------------------
module tsp_axis #(
	parameter int FULL_TURN  = 36000,
	parameter int TIMER_BITS = 16,
	parameter bit WRAP       = 1'b1
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire tsp_pkg::axis_ctl_t   ctl,
	input  wire tsp_pkg::cfg_t        cfg,
	input  wire  [15:0]               target_value,
	input  wire  [15:0]               cur,
	input  wire                       limit_ok,
	output tsp_pkg::axis_stat_t       stat
);

	localparam logic signed [17:0] TURN = 18'(FULL_TURN);
	localparam logic signed [17:0] HALF = 18'(FULL_TURN / 2);
	localparam logic [31:0] TMAX = 32'((64'd1 << TIMER_BITS) - 64'd1);

	logic [15:0]           tgt_q;
	logic                  valid_q;
	logic [TIMER_BITS-1:0] timer_q;
	logic [6:0]            left_q;
	logic                  dir_q, fast_q, moving_q;

	logic [TIMER_BITS-1:0] half_fast, half_slow;
	logic signed [17:0]    err_raw, err_w;
	logic [16:0]           mag;
	logic                  in_band, far, eval, start;
	logic [5:0]            n_pulses;
	logic [6:0]            left_a, left_n, left_dec;
	logic [TIMER_BITS-1:0] timer_a, timer_n;
	logic                  fast_a, dir_n, moving_n, valid_n;

	function automatic logic [TIMER_BITS-1:0] sat_half(input logic [15:0] v);
		logic [31:0] w;
		w = {16'd0, v};
		if (w == 32'd0)
			w = 32'd1;
		if (w > TMAX)
			w = TMAX;
		return w[TIMER_BITS-1:0];
	endfunction

	always_comb begin
		half_fast = sat_half(cfg.fast_half_period);
		half_slow = sat_half(cfg.slow_half_period);

		err_raw = $signed({2'b00, tgt_q}) - $signed({2'b00, cur});
		err_w = err_raw;
		if (WRAP) begin
			if (err_raw > HALF)
				err_w = err_raw - TURN;
			else if (err_raw < -HALF)
				err_w = err_raw + TURN;
		end
		mag = err_w[17] ? 17'(-err_w) : 17'(err_w);
		in_band = mag <= {2'b00, cfg.reach_tol};
		far = mag > {2'b00, cfg.speed_threshold};

		eval = ctl.tick && (left_q == 7'd0) && valid_q;
		start = eval && !in_band && limit_ok;
		n_pulses = (cfg.pulses_per_burst == 6'd0) ? 6'd1 : cfg.pulses_per_burst;

		left_a = start ? {n_pulses, 1'b0} : left_q;
		timer_a = start ? (far ? half_fast : half_slow) : timer_q;
		fast_a = start ? far : fast_q;
		dir_n = start ? (!err_w[17] && (err_w != 18'sd0)) : dir_q;

		// advance the phase timer on a tick
		left_dec = left_a - 7'd1;
		left_n = left_a;
		timer_n = timer_a;
		if (ctl.tick && (left_a != 7'd0)) begin
			if (timer_a <= TIMER_BITS'(1)) begin
				left_n = left_dec;
				timer_n = (left_dec != 7'd0) ? (fast_a ? half_fast : half_slow)
				                             : '0;
			end else begin
				timer_n = timer_a - TIMER_BITS'(1);
			end
		end

		moving_n = moving_q;
		if (ctl.tick && (left_q == 7'd0))
			moving_n = start;

		valid_n = valid_q;
		if (eval && in_band)
			valid_n = 1'b0;
		if (ctl.set)
			valid_n = 1'b1;

		if (ctl.stop) begin
			left_n = 7'd0;
			timer_n = '0;
			moving_n = 1'b0;
			valid_n = 1'b0;
		end

		stat.step = !ctl.stop && (left_a != 7'd0) && !left_a[0];
		stat.dir = dir_n;
		stat.moving = moving_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_q <= '0;
			valid_q <= 1'b0;
			timer_q <= '0;
			left_q <= '0;
			dir_q <= 1'b0;
			fast_q <= 1'b0;
			moving_q <= 1'b0;
		end else begin
			if (ctl.set)
				tgt_q <= target_value;
			valid_q <= valid_n;
			timer_q <= timer_n;
			left_q <= left_n;
			dir_q <= dir_n;
			fast_q <= fast_a;
			moving_q <= moving_n;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/two_axis_stepper_positioner.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_axis_stepper_positioner: two-speed bang-bang stepper position control
// Results: each beat is registered in the output register, or in the skid
// stage if the output stalls. Throughput: one item per cycle while the skid
// stage is empty; it keeps input acceptance going while a result waits.
// Reset: asynchronous, clears targets, bursts, flags and restores register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module two_axis_stepper_positioner #(
	parameter int FULL_TURN  = 36000,
	parameter int TIMER_BITS = 16
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_stall,
	input  wire tsp_pkg::in_item_t                 in_item,
	output logic                                   out_valid,
	input  wire                                    out_stall,
	output tsp_pkg::out_item_t                     out_item,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [tsp_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  wire  [tsp_pkg::CFG_DATA_W-1:0]         cfg_data
);

	tsp_pkg::cfg_t       cfg_q;
	tsp_pkg::axis_ctl_t  ctl_az, ctl_el;
	tsp_pkg::axis_stat_t stat_az, stat_el;
	tsp_pkg::out_item_t  res, out_item_q, skid_item_q;
	logic                out_valid_q, skid_valid_q;
	logic                accept;

	assign cfg_ready = 1'b1;
	assign in_stall = skid_valid_q;
	assign accept = in_valid && !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reach_tol <= tsp_pkg::RST_TOLERANCE;
			cfg_q.speed_threshold <= tsp_pkg::RST_THRESHOLD;
			cfg_q.fast_half_period <= tsp_pkg::RST_FAST_HALF;
			cfg_q.slow_half_period <= tsp_pkg::RST_SLOW_HALF;
			cfg_q.pulses_per_burst <= tsp_pkg::RST_PULSES;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tsp_pkg::CFG_TOLERANCE: cfg_q.reach_tol <= cfg_data[14:0];
				tsp_pkg::CFG_THRESHOLD: cfg_q.speed_threshold <= cfg_data[14:0];
				tsp_pkg::CFG_FAST_HALF: cfg_q.fast_half_period <= cfg_data;
				tsp_pkg::CFG_SLOW_HALF: cfg_q.slow_half_period <= cfg_data;
				tsp_pkg::CFG_PULSES:    cfg_q.pulses_per_burst <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ctl_az.tick = accept && (in_item.req_type == tsp_pkg::REQ_TICK);
		ctl_az.set = accept && (in_item.req_type == tsp_pkg::REQ_SET_AZ);
		ctl_az.stop = accept && (in_item.req_type == tsp_pkg::REQ_STOP);
		ctl_el.tick = ctl_az.tick;
		ctl_el.set = accept && (in_item.req_type == tsp_pkg::REQ_SET_EL);
		ctl_el.stop = ctl_az.stop;
	end

	tsp_axis #(
		.FULL_TURN  (FULL_TURN),
		.TIMER_BITS (TIMER_BITS),
		.WRAP       (1'b1)
	) u_axis_az (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_az),
		.cfg          (cfg_q),
		.target_value (in_item.target_value),
		.cur          (in_item.cur_az),
		.limit_ok     (in_item.limit_az_ok),
		.stat         (stat_az)
	);

	tsp_axis #(
		.FULL_TURN  (FULL_TURN),
		.TIMER_BITS (TIMER_BITS),
		.WRAP       (1'b0)
	) u_axis_el (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl_el),
		.cfg          (cfg_q),
		.target_value (in_item.target_value),
		.cur          (in_item.cur_el),
		.limit_ok     (in_item.limit_el_ok),
		.stat         (stat_el)
	);

	always_comb begin
		res.step_az = stat_az.step;
		res.dir_az = stat_az.dir;
		res.step_el = stat_el.step;
		res.dir_el = stat_el.dir;
		res.moving_az = stat_az.moving;
		res.moving_el = stat_el.moving;
	end

	// output register with a one-beat skid behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && out_stall) begin
			if (accept)
				skid_valid_q <= 1'b1;
		end else if (skid_valid_q) begin
			out_valid_q <= 1'b1;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out_stall) begin
			if (accept)
				skid_item_q <= res;
		end else if (skid_valid_q) begin
			out_item_q <= skid_item_q;
		end else if (accept) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item = out_item_q;

endmodule
`default_nettype wire

// ===== test/two_axis_stepper_positioner_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// two_axis_stepper_positioner_tb: self-checking bench for the positioner
// Feeds ticks and commands through the valid/stall input channel, predicts
// the pin levels of every result beat with an independent model of both
// axes, and compares them field by field. Runs a directed opening and a
// series of random phases under different register settings, with random
// gaps on the sender, random stalls on the receiver and full drains between
// phases.
// ----------------------------------------------------------------------------
module two_axis_stepper_positioner_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsp_pkg::*;

	localparam int FULL_TURN = 36000;
	localparam int HALF_TURN = FULL_TURN / 2;
	localparam int AZ = 0;
	localparam int EL = 1;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PRINT_CAP = 200;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_IDX = 3'd7;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_item;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	two_axis_stepper_positioner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// register copy
	logic [14:0] tol_r = RST_TOLERANCE;
	logic [14:0] thr_r = RST_THRESHOLD;
	logic [15:0] fast_r = RST_FAST_HALF;
	logic [15:0] slow_r = RST_SLOW_HALF;
	logic [5:0] burst_r = RST_PULSES;

	// axis state of the pin model
	logic [15:0] goal [2] = '{16'd0, 16'd0};
	bit goal_ok [2] = '{1'b0, 1'b0};
	logic [15:0] phase_ticks [2] = '{16'd0, 16'd0};
	logic [6:0] phases_left [2] = '{7'd0, 7'd0};
	bit dir_f [2] = '{1'b0, 1'b0};
	bit fast_f [2] = '{1'b0, 1'b0};
	bit moving_f [2] = '{1'b0, 1'b0};

	in_item_t pending [$];
	out_item_t pins_due [$];
	int items_queued = 0;
	int in_beats = 0;
	int out_beats = 0;
	int cycles = 0;
	int mismatches = 0;
	bit calm = 1'b0;
	logic [15:0] aim [2] = '{16'd0, 16'd0};

	function automatic logic [15:0] half_ticks(bit far);
		logic [15:0] v;
		v = far ? fast_r : slow_r;
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// one tick of one axis; returns the step level during the tick
	function automatic bit axis_advance(int ax, logic [15:0] cur, bit lim_ok);
		int err;
		int mag;
		bit lvl;
		lvl = 1'b0;
		if (phases_left[ax] == 7'd0) begin
			if (!goal_ok[ax]) begin
				moving_f[ax] = 1'b0;
			end else begin
				err = int'(goal[ax]) - int'(cur);
				if (ax == AZ) begin
					if (err > HALF_TURN)
						err -= FULL_TURN;
					else if (err < -HALF_TURN)
						err += FULL_TURN;
				end
				mag = (err < 0) ? -err : err;
				if (mag <= int'(tol_r)) begin
					goal_ok[ax] = 1'b0;
					moving_f[ax] = 1'b0;
				end else if (!lim_ok) begin
					moving_f[ax] = 1'b0;
				end else begin
					fast_f[ax] = mag > int'(thr_r);
					dir_f[ax] = err > 0;
					moving_f[ax] = 1'b1;
					phases_left[ax] = 7'(2 * ((burst_r == 6'd0) ? 1 : int'(burst_r)));
					phase_ticks[ax] = half_ticks(fast_f[ax]);
				end
			end
		end
		if (phases_left[ax] != 7'd0) begin
			lvl = !phases_left[ax][0];
			if (phase_ticks[ax] <= 16'd1) begin
				phases_left[ax] = phases_left[ax] - 7'd1;
				phase_ticks[ax] = (phases_left[ax] != 7'd0) ? half_ticks(fast_f[ax]) : 16'd0;
			end else begin
				phase_ticks[ax] = phase_ticks[ax] - 16'd1;
			end
		end
		return lvl;
	endfunction

	function automatic out_item_t predict_pins(in_item_t it);
		out_item_t o;
		bit saz;
		bit sel;
		case (it.req_type)
			REQ_TICK: begin
				saz = axis_advance(AZ, it.cur_az, it.limit_az_ok);
				sel = axis_advance(EL, it.cur_el, it.limit_el_ok);
			end
			REQ_SET_AZ: begin
				goal[AZ] = it.target_value;
				goal_ok[AZ] = 1'b1;
			end
			REQ_SET_EL: begin
				goal[EL] = it.target_value;
				goal_ok[EL] = 1'b1;
			end
			default: begin
				for (int ax = AZ; ax <= EL; ax++) begin
					goal_ok[ax] = 1'b0;
					phases_left[ax] = 7'd0;
					phase_ticks[ax] = 16'd0;
					moving_f[ax] = 1'b0;
				end
			end
		endcase
		if (it.req_type != REQ_TICK) begin
			saz = phases_left[AZ] != 7'd0 && !phases_left[AZ][0];
			sel = phases_left[EL] != 7'd0 && !phases_left[EL][0];
		end
		o.step_az = saz;
		o.dir_az = dir_f[AZ];
		o.step_el = sel;
		o.dir_el = dir_f[EL];
		o.moving_az = moving_f[AZ];
		o.moving_el = moving_f[EL];
		return o;
	endfunction

	task automatic report(string msg);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0d] MISMATCH %s", cycles, msg);
	endtask

	task automatic check_field(string name, logic got, logic want);
		if (got !== want)
			report($sformatf("%s: got %b, want %b", name, got, want));
	endtask

	function automatic int pause_len();
		if (calm || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	// monitor: check result beats, predict accepted items
	always @(posedge clk) begin
		out_item_t want;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("two_axis_stepper_positioner test failed");
			$finish;
		end else if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pins_due.size() == 0) begin
					report("result beat with no item pending");
				end else begin
					want = pins_due.pop_front();
					check_field("step_az", out_item.step_az, want.step_az);
					check_field("dir_az", out_item.dir_az, want.dir_az);
					check_field("step_el", out_item.step_el, want.step_el);
					check_field("dir_el", out_item.dir_el, want.dir_el);
					check_field("moving_az", out_item.moving_az, want.moving_az);
					check_field("moving_el", out_item.moving_el, want.moving_el);
				end
				out_beats++;
			end
			if (in_valid && !in_stall) begin
				pins_due.push_back(predict_pins(in_item));
				in_beats++;
			end
		end
	end

	// driver: present pending items with a random gap between them
	int sent_seen = 0;
	int gap_left = 0;
	always @(negedge clk) begin
		logic nv;
		in_item_t ni;
		nv = in_valid;
		ni = in_item;
		if (in_valid && in_beats != sent_seen) begin
			sent_seen = in_beats;
			nv = 1'b0;
		end
		if (!nv) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending.size() != 0) begin
				ni = pending.pop_front();
				nv = 1'b1;
				gap_left = pause_len();
			end
		end
		in_valid <= nv;
		in_item <= ni;
	end

	// receiver: stall for a random count after each result beat
	int stall_seen = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (out_beats != stall_seen) begin
			stall_seen = out_beats;
			stall_left = pause_len();
		end
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	task automatic send(in_item_t it);
		pending.push_back(it);
		items_queued++;
	endtask

	task automatic queue_item(req_t req, logic [15:0] tv, logic [15:0] caz,
			logic [15:0] cel, logic laz, logic lel);
		in_item_t it;
		it.req_type = req;
		it.target_value = tv;
		it.cur_az = caz;
		it.cur_el = cel;
		it.limit_az_ok = laz;
		it.limit_el_ok = lel;
		send(it);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_TOLERANCE: tol_r = data[14:0];
			CFG_THRESHOLD: thr_r = data[14:0];
			CFG_FAST_HALF: fast_r = data;
			CFG_SLOW_HALF: slow_r = data;
			CFG_PULSES:    burst_r = data[5:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(logic [15:0] tol, logic [15:0] thr, logic [15:0] fast,
			logic [15:0] slow, logic [15:0] pulses);
		write_reg(CFG_TOLERANCE, tol);
		write_reg(CFG_THRESHOLD, thr);
		write_reg(CFG_FAST_HALF, fast);
		write_reg(CFG_SLOW_HALF, slow);
		write_reg(CFG_PULSES, pulses);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// hold until every item is taken and every result is back, then idle a bit
	task automatic settle();
		while (in_beats != items_queued || pins_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function automatic logic [15:0] rand_angle();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(0, 65535));
		return 16'($urandom_range(0, 35999));
	endfunction

	// encoder reading placed around a target so errors straddle the bounds
	function automatic logic [15:0] sensed(logic [15:0] goal_at);
		int d;
		int v;
		case ($urandom_range(0, 5))
			0: d = int'(tol_r) + $urandom_range(0, 1);
			1: d = int'(thr_r) + $urandom_range(0, 1);
			2: d = $urandom_range(0, 40);
			3: d = $urandom_range(0, 2000);
			4: return rand_angle();
			default: d = $urandom_range(0, HALF_TURN + 1);
		endcase
		if ($urandom_range(0, 1) == 1)
			d = -d;
		v = int'(goal_at) - d;
		v = ((v % FULL_TURN) + FULL_TURN) % FULL_TURN;
		return 16'(v);
	endfunction

	task automatic run_random(int n);
		in_item_t it;
		int pick;
		repeat (n) begin
			pick = $urandom_range(0, 99);
			it.target_value = rand_angle();
			it.cur_az = sensed(aim[AZ]);
			it.cur_el = sensed(aim[EL]);
			it.limit_az_ok = $urandom_range(0, 7) != 0;
			it.limit_el_ok = $urandom_range(0, 7) != 0;
			if (pick < 6) begin
				it.req_type = REQ_SET_AZ;
				aim[AZ] = it.target_value;
			end else if (pick < 12) begin
				it.req_type = REQ_SET_EL;
				aim[EL] = it.target_value;
			end else if (pick < 14) begin
				it.req_type = REQ_STOP;
			end else begin
				it.req_type = REQ_TICK;
			end
			send(it);
		end
		// abort any running burst before the next register change
		queue_item(REQ_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		settle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// directed opening on the reset settings
		queue_item(REQ_TICK, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
		queue_item(REQ_SET_AZ, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd18000, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd18000, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_SET_EL, 16'd35999, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd18000, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_STOP, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_SET_AZ, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd18001, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_STOP, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0);
		queue_item(REQ_SET_AZ, 16'd35999, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_SET_AZ, 16'd100, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd110, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_SET_AZ, 16'd100, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd111, 16'd0, 1'b0, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd111, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_STOP, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		queue_item(REQ_SET_EL, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd0, 16'hFFFF, 1'b1, 1'b1);
		queue_item(REQ_STOP, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_SET_AZ, 16'hFFFF, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_SET_EL, 16'd500, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_TICK, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0);
		queue_item(REQ_TICK, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		queue_item(REQ_STOP, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1);
		settle();

		load_settings(16'd10, 16'd500, 16'd1, 16'd3, 16'd2);
		run_random(350);

		// zero tolerance and threshold, zero fast half period and burst length
		load_settings(16'd0, 16'd0, 16'd0, 16'd65535, 16'd0);
		run_random(250);

		calm = 1'b1;
		load_settings(16'd18000, 16'd18000, 16'd2, 16'd1, 16'd63);
		run_random(250);

		// spare index and upper data bits beyond the register width
		calm = 1'b0;
		write_reg(CFG_SPARE_IDX, 16'hFFFF);
		load_settings(16'h8014, 16'h812C, 16'd3, 16'd1, 16'hFFC1);
		run_random(250);

		calm = 1'b1;
		load_settings(16'd40, 16'd120, 16'd65535, 16'd65535, 16'd63);
		run_random(200);

		repeat (3) begin
			calm = $urandom_range(0, 3) == 0;
			load_settings(16'($urandom_range(0, 60)), 16'($urandom_range(0, 400)),
				16'($urandom_range(1, 3)), 16'($urandom_range(0, 6)),
				16'($urandom_range(1, 4)));
			run_random(250);
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("two_axis_stepper_positioner test passed");
		else
			$display("two_axis_stepper_positioner test failed");
		$finish;
	end

endmodule
`default_nettype wire
